// ===== hw/rtl/qte_pkg.sv =====
// Shared types, widths and constants for the quaternion to Euler angle pipeline.
// No dependencies.
package qte_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int SQRT_STEPS   = 29;
   localparam int SW           = 35;   // quadratic term width, Q28
   localparam int CW           = 37;   // cordic x/y width
   localparam int ZW           = 27;   // angle accumulator, 1/65536 degree
   localparam int RADW         = 2 * SQRT_STEPS;

   localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
   localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
   localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd1 << 28);
   localparam logic [15:0] ROLL_LIM  = 16'd23040;
   localparam logic [15:0] PITCH_LIM = 16'd11520;

   typedef struct packed {
      logic signed [SW-1:0] sr;
      logic signed [SW-1:0] cr;
      logic signed [SW-1:0] sy;
      logic signed [SW-1:0] cy;
      logic signed [SW-1:0] sp;
      logic                 clamped;
   } side_type;

   function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      unique case (idx)
         5'd0:  v = ZW'(2949120);
         5'd1:  v = ZW'(1740967);
         5'd2:  v = ZW'(919879);
         5'd3:  v = ZW'(466945);
         5'd4:  v = ZW'(234379);
         5'd5:  v = ZW'(117304);
         5'd6:  v = ZW'(58666);
         5'd7:  v = ZW'(29335);
         5'd8:  v = ZW'(14668);
         5'd9:  v = ZW'(7334);
         5'd10: v = ZW'(3667);
         5'd11: v = ZW'(1833);
         5'd12: v = ZW'(917);
         5'd13: v = ZW'(458);
         5'd14: v = ZW'(229);
         5'd15: v = ZW'(115);
         5'd16: v = ZW'(57);
         5'd17: v = ZW'(29);
         5'd18: v = ZW'(14);
         5'd19: v = ZW'(7);
         5'd20: v = ZW'(4);
         5'd21: v = ZW'(2);
         5'd22: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/qte_front.sv =====
// Front end: quaternion products, quadratic terms, and the pitch cosine radicand.
// Depends on qte_pkg.
module qte_front import qte_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [15:0]      quat_w,
   input  logic signed [15:0]      quat_x,
   input  logic signed [15:0]      quat_y,
   input  logic signed [15:0]      quat_z,
   output logic                    out_valid,
   output logic [RADW-1:0]         out_rad,
   output side_type                out_side
);

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   logic [2:0]         vld_ff, vld_in;
   side_type           sb_ff, sb_in, sc_ff;
   logic signed [SW-1:0] wy_zx;
   logic [28:0]        sp_abs;
   logic [57:0]        sq;
   logic [RADW-1:0]    rad_ff, rad_in;

   assign vld_in = {vld_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= quat_w * quat_x;
         yz_ff <= quat_y * quat_z;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         wy_ff <= quat_w * quat_y;
         zx_ff <= quat_z * quat_x;
         wz_ff <= quat_w * quat_z;
         xy_ff <= quat_x * quat_y;
         zz_ff <= quat_z * quat_z;
         sb_ff <= sb_in;
         sc_ff <= sb_ff;
         rad_ff <= rad_in;
      end
   end

   always_comb begin
      wy_zx = SW'(wy_ff) - SW'(zx_ff);
      sb_in.sr = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      sb_in.cr = ONE_Q28 - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
      sb_in.sy = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
      sb_in.cy = ONE_Q28 - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      sb_in.sp = wy_zx <<< 1;
      sb_in.clamped = (sb_in.sp >= ONE_Q28) || (sb_in.sp <= -ONE_Q28);
   end

   // only meaningful when not clamped: |sp| < 2^28
   assign sp_abs = sb_ff.sp[SW-1] ? 29'(-sb_ff.sp) : sb_ff.sp[28:0];
   assign sq     = 58'(sp_abs) * 58'(sp_abs);
   assign rad_in = RADW'((58'd1 << 56) - sq);

   assign out_valid = vld_ff[2];
   assign out_rad   = rad_ff;
   assign out_side  = sc_ff;

endmodule

// ===== hw/rtl/qte_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, side payload carried along.
// Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [RADW-1:0]         in_rad,
   input  side_type                in_side,
   output logic                    out_valid,
   output logic [SQRT_STEPS-1:0]   out_root,
   output side_type                out_side
);

   logic                   vld_ff  [SQRT_STEPS+1];
   logic [RADW-1:0]        rad_ff  [SQRT_STEPS+1];
   logic [29:0]            rem_ff  [SQRT_STEPS+1];
   logic [SQRT_STEPS-1:0]  root_ff [SQRT_STEPS+1];
   side_type               side_ff [SQRT_STEPS+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      rad_ff[0]  = in_rad;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      side_ff[0] = in_side;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [31:0] cat;
      logic [31:0] trial;
      logic        take;
      logic [29:0] rem_in;
      logic [SQRT_STEPS-1:0] root_in;

      always_comb begin
         cat     = {rem_ff[k], rad_ff[k][RADW-1 -: 2]};
         trial   = 32'({root_ff[k][SQRT_STEPS-2:0], 2'b01});
         take    = cat >= trial;
         rem_in  = take ? 30'(cat - trial) : cat[29:0];
         root_in = {root_ff[k][SQRT_STEPS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k+1]  <= rad_ff[k] << 2;
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS];
   assign out_side  = side_ff[SQRT_STEPS];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2, one iteration per stage, degrees*128 output.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic                    in_tag,
   input  logic signed [CW-1:0]    in_y,
   input  logic signed [CW-1:0]    in_x,
   input  logic [15:0]             sat_lim,
   output logic                    out_valid,
   output logic                    out_tag,
   output logic signed [15:0]      out_angle
);

   logic                   vld_ff [CORDIC_STEPS+1];
   logic                   tag_ff [CORDIC_STEPS+1];
   logic                   fix_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]   x_ff   [CORDIC_STEPS+1];
   logic signed [CW-1:0]   y_ff   [CORDIC_STEPS+1];
   logic signed [ZW-1:0]   z_ff   [CORDIC_STEPS+1];

   logic                   fix_in;
   logic signed [CW-1:0]   x_in, y_in;
   logic signed [ZW-1:0]   z_in;

   always_comb begin
      fix_in = 1'b0;
      x_in   = in_x;
      y_in   = in_y;
      z_in   = '0;
      priority if (in_y == '0) begin
         fix_in = 1'b1;
         z_in   = in_x[CW-1] ? DEG180 : '0;
      end else if (in_x == '0) begin
         fix_in = 1'b1;
         z_in   = in_y[CW-1] ? -DEG90 : DEG90;
      end else if (in_x[CW-1]) begin
         z_in = in_y[CW-1] ? -DEG180 : DEG180;
         x_in = -in_x;
         y_in = -in_y;
      end else begin
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         fix_ff[0] <= fix_in;
         x_ff[0]   <= x_in;
         y_ff[0]   <= y_in;
         z_ff[0]   <= z_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CW-1:0] xs, ys, x_nx, y_nx;
      logic signed [ZW-1:0] z_nx;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (y_ff[i] > 0) begin
            x_nx = x_ff[i] + ys;
            y_nx = y_ff[i] - xs;
            z_nx = z_ff[i] + atan_tab(5'(i));
         end else begin
            x_nx = x_ff[i] - ys;
            y_nx = y_ff[i] + xs;
            z_nx = z_ff[i] - atan_tab(5'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[i+1] <= tag_ff[i];
            fix_ff[i+1] <= fix_ff[i];
            x_ff[i+1]   <= fix_ff[i] ? x_ff[i] : x_nx;
            y_ff[i+1]   <= fix_ff[i] ? y_ff[i] : y_nx;
            z_ff[i+1]   <= fix_ff[i] ? z_ff[i] : z_nx;
         end
      end
   end

   logic signed [ZW-1:0]   zr;
   logic signed [ZW-10:0]  deg;
   logic signed [ZW-10:0]  lim;
   logic signed [15:0]     ang_in;
   logic                   vld_out_ff, tag_out_ff;
   logic signed [15:0]     ang_ff;

   always_comb begin
      zr  = z_ff[CORDIC_STEPS] + ZW'(256);
      deg = zr[ZW-1:9];
      lim = (ZW-9)'(sat_lim);
      priority if (deg > lim) begin
         ang_in = 16'(lim);
      end else if (deg < -lim) begin
         ang_in = 16'(-lim);
      end else begin
         ang_in = 16'(deg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_out_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_out_ff <= tag_ff[CORDIC_STEPS];
         ang_ff     <= ang_in;
      end
   end

   assign out_valid = vld_out_ff;
   assign out_tag   = tag_out_ff;
   assign out_angle = ang_ff;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Quaternion (Q1.14) to ZYX roll/pitch/yaw in degrees*128.
// Pipeline: 3 product/term stages, 29 square root stages, 18 CORDIC stages.
// Throughput one item per cycle; the whole pipeline holds while a result is not taken.
// Synchronous active-high reset clears the valid bits only.
// Depends on qte_pkg, qte_front, qte_isqrt, qte_cordic.
module quaternion_to_euler_angles import qte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata     // roll_deg, pitch_deg, yaw_deg, pitch_clamped
);

   logic                  en;
   logic                  f_valid, s_valid;
   logic [RADW-1:0]       f_rad;
   side_type              f_side, s_side;
   logic [SQRT_STEPS-1:0] s_root;
   logic                  r_valid, y_valid, p_valid, p_tag;
   logic                  r_tag, y_tag;
   logic signed [15:0]    roll, yaw, pitch;
   logic signed [CW-1:0]  p_y, p_x;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .quat_w    (req_tdata[15:0]),
      .quat_x    (req_tdata[31:16]),
      .quat_y    (req_tdata[47:32]),
      .quat_z    (req_tdata[63:48]),
      .out_valid (f_valid),
      .out_rad   (f_rad),
      .out_side  (f_side)
   );

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rad    (f_rad),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // clamped pitch goes in as x = 0, which the CORDIC maps to +/-90 degrees
   assign p_y = CW'(s_side.sp);
   assign p_x = s_side.clamped ? '0 : CW'(s_root);

   qte_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_tag    (1'b0),
      .in_y      (CW'(s_side.sr)),
      .in_x      (CW'(s_side.cr)),
      .sat_lim   (ROLL_LIM),
      .out_valid (r_valid),
      .out_tag   (r_tag),
      .out_angle (roll)
   );

   qte_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_tag    (s_side.clamped),
      .in_y      (p_y),
      .in_x      (p_x),
      .sat_lim   (PITCH_LIM),
      .out_valid (p_valid),
      .out_tag   (p_tag),
      .out_angle (pitch)
   );

   qte_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_tag    (1'b0),
      .in_y      (CW'(s_side.sy)),
      .in_x      (CW'(s_side.cy)),
      .sat_lim   (ROLL_LIM),
      .out_valid (y_valid),
      .out_tag   (y_tag),
      .out_angle (yaw)
   );

   assign rsp_tvalid = p_valid;
   assign rsp_tdata  = {p_tag, yaw, pitch[14:0], roll};

`ifndef SYNTH
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (r_valid == p_valid) && (y_valid == p_valid) && !(p_valid && (r_tag || y_tag)))
      else $error("cordic lanes out of step");

   a_clamp_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && p_tag |-> (pitch == 16'sd11520) || (pitch == -16'sd11520))
      else $error("clamped pitch not at +/-90");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (roll <= 16'sd23040) && (roll >= -16'sd23040)
                     && (yaw <= 16'sd23040) && (yaw >= -16'sd23040))
      else $error("roll or yaw out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
`endif

endmodule
